// File: src/rafe_pkg.sv
`timescale 1ns / 1ps

package rafe_pkg;

  localparam int OPCODE_W   = 2;
  localparam int POS_W      = 13;
  localparam int SIZE_W     = 14;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int ACT_W_W    = 12;
  localparam int ACT_H_W    = 7;
  localparam int CHAN_W     = 8;
  localparam int BLEND_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'b1;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_FILL  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_CLEAR,
    BK_FILL_RD,
    BK_FILL_MUL,
    BK_FILL_WR,
    BK_READ_RD,
    BK_READ_OUT
  } back_state_t;

  // Exact floor(v / 255) for any v up to 255 * 255.
  function automatic logic [CHAN_W-1:0] div255(input logic [BLEND_W-1:0] v);
    logic [BLEND_W:0] t;
    t = {1'b0, v} + 17'd1 + {9'd0, v[BLEND_W-1:CHAN_W]};
    return t[BLEND_W-1:CHAN_W];
  endfunction

endpackage

// File: src/rafe_ram.sv
`timescale 1ns / 1ps

module rafe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/rafe_fifo.sv
`timescale 1ns / 1ps

module rafe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/rafe_front.sv
`timescale 1ns / 1ps

module rafe_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [rafe_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [rafe_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                                    start,
  input  logic [rafe_pkg::OPCODE_W-1:0]           in_opcode,
  input  logic signed [rafe_pkg::POS_W-1:0]       in_pos_x,
  input  logic signed [rafe_pkg::POS_W-1:0]       in_pos_y,
  input  logic signed [rafe_pkg::SIZE_W-1:0]      in_rect_w,
  input  logic signed [rafe_pkg::SIZE_W-1:0]      in_rect_h,
  input  logic [rafe_pkg::COLOR_W-1:0]            in_color,
  input  logic                                    hold,
  input  logic                                    q_full,
  output logic                                    busy,
  output logic                                    push,
  output rafe_pkg::cmd_kind_t                     push_kind,
  output logic                                    push_draw,
  output logic [((MAX_WIDTH * MAX_HEIGHT > 1) ?
                 $clog2(MAX_WIDTH * MAX_HEIGHT) : 1)-1:0] push_base,
  output logic [$clog2(MAX_WIDTH + 1)-1:0]        push_cols,
  output logic [$clog2(MAX_HEIGHT + 1)-1:0]       push_rows,
  output logic [rafe_pkg::COLOR_W-1:0]            push_color
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);

  logic [rafe_pkg::ACT_W_W-1:0] act_w_r;
  logic [rafe_pkg::ACT_H_W-1:0] act_h_r;
  logic [XW-1:0]                eff_w;
  logic [YW-1:0]                eff_h;

  logic signed [15:0] xs, ys, wd, hd, x_end, y_end, x0, y0, x1, y1;
  logic               accept;
  rafe_pkg::cmd_kind_t kind;

  logic                s1_valid_r, s1_valid_nxt;
  rafe_pkg::cmd_kind_t s1_kind_r, s1_kind_nxt;
  logic                s1_draw_r, s1_draw_nxt;
  logic [XW-1:0]       s1_x0_r, s1_x0_nxt;
  logic [YW-1:0]       s1_y0_r, s1_y0_nxt;
  logic [XW-1:0]       s1_cols_r, s1_cols_nxt;
  logic [YW-1:0]       s1_rows_r, s1_rows_nxt;
  logic [rafe_pkg::COLOR_W-1:0] s1_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_w_r <= '0;
      act_h_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rafe_pkg::REG_ACTIVE_WIDTH:  act_w_r <= cfg_wdata;
        rafe_pkg::REG_ACTIVE_HEIGHT: act_h_r <= cfg_wdata[rafe_pkg::ACT_H_W-1:0];
      endcase
    end
  end

  // An area register above the store size counts as the store size.
  assign eff_w = (32'(act_w_r) > 32'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(act_w_r);
  assign eff_h = (32'(act_h_r) > 32'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(act_h_r);

  assign busy   = hold || (s1_valid_r && q_full);
  assign accept = start && !busy;
  assign push   = s1_valid_r && !q_full;
  assign kind   = rafe_pkg::cmd_kind_t'(in_opcode);

  always_comb begin
    xs    = 16'(in_pos_x);
    ys    = 16'(in_pos_y);
    wd    = signed'(16'(eff_w));
    hd    = signed'(16'(eff_h));
    x_end = xs + 16'(in_rect_w);
    y_end = ys + 16'(in_rect_h);
    x0    = (xs < 16'sd0) ? 16'sd0 : xs;
    y0    = (ys < 16'sd0) ? 16'sd0 : ys;
    x1    = (x_end < wd) ? x_end : wd;
    y1    = (y_end < hd) ? y_end : hd;
  end

  always_comb begin
    s1_kind_nxt = kind;
    s1_draw_nxt = 1'b0;
    s1_x0_nxt   = '0;
    s1_y0_nxt   = '0;
    s1_cols_nxt = eff_w;
    s1_rows_nxt = eff_h;
    unique case (kind)
      rafe_pkg::OP_CLEAR: begin
        s1_draw_nxt = (eff_w != '0) && (eff_h != '0);
      end
      rafe_pkg::OP_FILL: begin
        s1_draw_nxt = (x1 > x0) && (y1 > y0);
        s1_x0_nxt   = XW'(x0);
        s1_y0_nxt   = YW'(y0);
        s1_cols_nxt = XW'(x1 - x0);
        s1_rows_nxt = YW'(y1 - y0);
      end
      rafe_pkg::OP_READ: begin
        s1_draw_nxt = (xs >= 16'sd0) && (xs < wd) && (ys >= 16'sd0) && (ys < hd);
        s1_x0_nxt   = XW'(xs);
        s1_y0_nxt   = YW'(ys);
        s1_cols_nxt = XW'(1);
        s1_rows_nxt = YW'(1);
      end
      rafe_pkg::OP_NONE: begin
        s1_draw_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r  <= s1_kind_nxt;
      s1_draw_r  <= s1_draw_nxt;
      s1_x0_r    <= s1_x0_nxt;
      s1_y0_r    <= s1_y0_nxt;
      s1_cols_r  <= s1_cols_nxt;
      s1_rows_r  <= s1_rows_nxt;
      s1_color_r <= in_color;
    end
  end

  assign push_kind  = s1_kind_r;
  assign push_draw  = s1_draw_r;
  assign push_base  = AW'(32'(s1_y0_r) * 32'(MAX_WIDTH) + 32'(s1_x0_r));
  assign push_cols  = s1_cols_r;
  assign push_rows  = s1_rows_r;
  assign push_color = s1_color_r;

endmodule

// File: src/rafe_back.sv
`timescale 1ns / 1ps

module rafe_back #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    q_valid,
  input  rafe_pkg::cmd_kind_t                     q_kind,
  input  logic                                    q_draw,
  input  logic [((MAX_WIDTH * MAX_HEIGHT > 1) ?
                 $clog2(MAX_WIDTH * MAX_HEIGHT) : 1)-1:0] q_base,
  input  logic [$clog2(MAX_WIDTH + 1)-1:0]        q_cols,
  input  logic [$clog2(MAX_HEIGHT + 1)-1:0]       q_rows,
  input  logic [rafe_pkg::COLOR_W-1:0]            q_color,
  output logic                                    q_pop,
  output logic                                    init_busy,
  output logic                                    out_valid,
  output logic [rafe_pkg::COLOR_W-1:0]            out_pixel_value,
  output logic                                    out_in_range
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int CH    = rafe_pkg::CHAN_W;
  localparam int BW    = rafe_pkg::BLEND_W;

  rafe_pkg::back_state_t state_r, state_nxt;

  logic [AW-1:0]  addr_r, row_base_r;
  logic [XW-1:0]  col_left_r, cols_r;
  logic [YW-1:0]  row_left_r;
  logic [rafe_pkg::COLOR_W-1:0] color_r;
  logic [BW-1:0]  sum_r_r, sum_g_r, sum_b_r;

  logic           ram_we;
  logic [rafe_pkg::COLOR_W-1:0] ram_wdata, ram_rdata;
  logic           last_px, step;
  logic           res_valid, res_in_range;
  logic [rafe_pkg::COLOR_W-1:0] res_value;
  logic           init_done;
  logic [CH-1:0]  alpha;
  logic [BW-1:0]  sum_r, sum_g, sum_b;

  logic           out_valid_r, out_in_range_r;
  logic [rafe_pkg::COLOR_W-1:0] out_pixel_value_r;

  rafe_ram #(
    .WIDTH (rafe_pkg::COLOR_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign last_px   = (col_left_r == XW'(1)) && (row_left_r == YW'(1));
  assign init_done = (addr_r == AW'(DEPTH - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rafe_pkg::BK_INIT: begin
        if (init_done) state_nxt = rafe_pkg::BK_IDLE;
      end
      rafe_pkg::BK_IDLE: begin
        if (q_valid && q_draw) begin
          unique case (q_kind)
            rafe_pkg::OP_CLEAR: state_nxt = rafe_pkg::BK_CLEAR;
            rafe_pkg::OP_FILL:  state_nxt = rafe_pkg::BK_FILL_RD;
            rafe_pkg::OP_READ:  state_nxt = rafe_pkg::BK_READ_RD;
            rafe_pkg::OP_NONE:  state_nxt = rafe_pkg::BK_IDLE;
          endcase
        end
      end
      rafe_pkg::BK_CLEAR: begin
        if (last_px) state_nxt = rafe_pkg::BK_IDLE;
      end
      rafe_pkg::BK_FILL_RD:  state_nxt = rafe_pkg::BK_FILL_MUL;
      rafe_pkg::BK_FILL_MUL: state_nxt = rafe_pkg::BK_FILL_WR;
      rafe_pkg::BK_FILL_WR: begin
        state_nxt = last_px ? rafe_pkg::BK_IDLE : rafe_pkg::BK_FILL_RD;
      end
      rafe_pkg::BK_READ_RD:  state_nxt = rafe_pkg::BK_READ_OUT;
      rafe_pkg::BK_READ_OUT: state_nxt = rafe_pkg::BK_IDLE;
      default:               state_nxt = rafe_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    ram_we       = 1'b0;
    ram_wdata    = color_r;
    q_pop        = 1'b0;
    step         = 1'b0;
    res_valid    = 1'b0;
    res_value    = '0;
    res_in_range = 1'b0;
    unique case (state_r)
      rafe_pkg::BK_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      rafe_pkg::BK_IDLE: begin
        q_pop = q_valid;
        // Commands that touch nothing report right away.
        res_valid = q_valid && !q_draw;
      end
      rafe_pkg::BK_CLEAR: begin
        ram_we    = 1'b1;
        step      = 1'b1;
        res_valid = last_px;
      end
      rafe_pkg::BK_FILL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {rafe_pkg::div255(sum_r_r), rafe_pkg::div255(sum_g_r),
                     rafe_pkg::div255(sum_b_r), rafe_pkg::CHAN_MAX};
        step      = 1'b1;
        res_valid = last_px;
      end
      rafe_pkg::BK_READ_OUT: begin
        res_valid    = 1'b1;
        res_value    = ram_rdata;
        res_in_range = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign alpha = color_r[CH-1:0];
  assign sum_r = BW'(ram_rdata[31:24]) * BW'(rafe_pkg::CHAN_MAX - alpha)
               + BW'(color_r[31:24]) * BW'(alpha);
  assign sum_g = BW'(ram_rdata[23:16]) * BW'(rafe_pkg::CHAN_MAX - alpha)
               + BW'(color_r[23:16]) * BW'(alpha);
  assign sum_b = BW'(ram_rdata[15:8]) * BW'(rafe_pkg::CHAN_MAX - alpha)
               + BW'(color_r[15:8]) * BW'(alpha);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rafe_pkg::BK_INIT;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_valid;
      if (state_r == rafe_pkg::BK_INIT) begin
        addr_r <= init_done ? '0 : addr_r + AW'(1);
      end else if (q_pop) begin
        addr_r <= q_base;
      end else if (step) begin
        addr_r <= (col_left_r == XW'(1)) ? row_base_r + AW'(MAX_WIDTH) : addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_value_r <= res_value;
    out_in_range_r    <= res_in_range;
    if (q_pop) begin
      row_base_r <= q_base;
      col_left_r <= q_cols;
      cols_r     <= q_cols;
      row_left_r <= q_rows;
      // Clear stores the command color with full alpha.
      color_r    <= (q_kind == rafe_pkg::OP_CLEAR) ?
                    {q_color[rafe_pkg::COLOR_W-1:CH], rafe_pkg::CHAN_MAX} : q_color;
    end else if (step) begin
      if (col_left_r == XW'(1)) begin
        row_base_r <= row_base_r + AW'(MAX_WIDTH);
        col_left_r <= cols_r;
        row_left_r <= row_left_r - YW'(1);
      end else begin
        col_left_r <= col_left_r - XW'(1);
      end
    end
    if (state_r == rafe_pkg::BK_FILL_MUL) begin
      sum_r_r <= sum_r;
      sum_g_r <= sum_g;
      sum_b_r <= sum_b;
    end
  end

  assign init_busy       = (state_r == rafe_pkg::BK_INIT);
  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pixel_value_r;
  assign out_in_range    = out_in_range_r;

endmodule

// File: src/rect_alpha_fill_engine.sv
`timescale 1ns / 1ps

// Small 2D drawing engine over an RGBA frame store of MAX_WIDTH x MAX_HEIGHT words.
// Commands enter on start/in_* and are taken at a clock edge where start is high
// and busy is low. Each command gives exactly one result: out_valid is high for one
// cycle with out_pixel_value and out_in_range. Results cannot be held off.
// The active area is set with cfg_we/cfg_index/cfg_wdata while no command is pending.
// A front stage clips and classifies a command into a register and hands it to a
// two-entry queue; the back end works the store one pixel at a time. Up to four
// commands can be in flight, so a new command is usually taken while one is drawn.
// Fill reads, blends and writes back each pixel in turn, since the read and write
// ports of the store share one address; clear writes one pixel per cycle.
// After reset the whole store is written to zero, one word per cycle; busy is high
// until the last word is written, and configuration writes are still taken.

module rect_alpha_fill_engine #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rafe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rafe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               start,
  output logic                               busy,
  input  logic [rafe_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic signed [rafe_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [rafe_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [rafe_pkg::SIZE_W-1:0] in_rect_w,
  input  logic signed [rafe_pkg::SIZE_W-1:0] in_rect_h,
  input  logic [rafe_pkg::COLOR_W-1:0]       in_color,
  output logic                               out_valid,
  output logic [rafe_pkg::COLOR_W-1:0]       out_pixel_value,
  output logic                               out_in_range
);

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW      = $clog2(MAX_WIDTH + 1);
  localparam int YW      = $clog2(MAX_HEIGHT + 1);
  localparam int KW      = rafe_pkg::OPCODE_W;
  localparam int EW      = KW + 1 + AW + XW + YW + rafe_pkg::COLOR_W;
  localparam int Q_DEPTH = 2;

  logic                         push, pop, q_full, q_empty, init_busy;
  rafe_pkg::cmd_kind_t          f_kind;
  logic                         f_draw;
  logic [AW-1:0]                f_base;
  logic [XW-1:0]                f_cols;
  logic [YW-1:0]                f_rows;
  logic [rafe_pkg::COLOR_W-1:0] f_color;
  logic [EW-1:0]                push_data, pop_data;

  rafe_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .start      (start),
    .in_opcode  (in_opcode),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_rect_w  (in_rect_w),
    .in_rect_h  (in_rect_h),
    .in_color   (in_color),
    .hold       (init_busy),
    .q_full     (q_full),
    .busy       (busy),
    .push       (push),
    .push_kind  (f_kind),
    .push_draw  (f_draw),
    .push_base  (f_base),
    .push_cols  (f_cols),
    .push_rows  (f_rows),
    .push_color (f_color)
  );

  assign push_data = {f_kind, f_draw, f_base, f_cols, f_rows, f_color};

  rafe_fifo #(
    .WIDTH (EW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  rafe_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (!q_empty),
    .q_kind          (rafe_pkg::cmd_kind_t'(pop_data[EW-1 -: KW])),
    .q_draw          (pop_data[EW-KW-1]),
    .q_base          (pop_data[EW-KW-2 -: AW]),
    .q_cols          (pop_data[XW+YW+rafe_pkg::COLOR_W-1 -: XW]),
    .q_rows          (pop_data[YW+rafe_pkg::COLOR_W-1 -: YW]),
    .q_color         (pop_data[rafe_pkg::COLOR_W-1:0]),
    .q_pop           (pop),
    .init_busy       (init_busy),
    .out_valid       (out_valid),
    .out_pixel_value (out_pixel_value),
    .out_in_range    (out_in_range)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("queue read while empty");

  a_quiet_outputs: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> (out_pixel_value == '0) && !out_in_range)
    else $error("result fields set without a result");

  a_busy_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> busy && q_empty)
    else $error("command taken during store clearing");

endmodule
